@@ hw/rtl/dhb_pkg.sv @@
// dhb_pkg: shared types, opcodes and constants of the dual h-bridge drive block
// no dependencies; used by dhb_front, dhb_fifo, dhb_back and the top level
package dhb_pkg;

  // field widths
  localparam int DUTY_W   = 12;
  localparam int REG_W    = 16;
  localparam int CMP_W    = 16;
  localparam int PERIOD_W = 7;
  localparam int CFG_IDXW = 3;

  // queue between front and back
  localparam int QDEPTH = 2;

  // host opcodes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_CONTACT    = 3'd1;
  localparam logic [2:0] OP_DRIVE      = 3'd2;
  localparam logic [2:0] OP_STOP_MOTOR = 3'd3;
  localparam logic [2:0] OP_STOP_ALL   = 3'd4;
  localparam logic [2:0] OP_ENC_ON     = 3'd5;
  localparam logic [2:0] OP_ENC_OFF    = 3'd6;

  // motor directions
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_A    = 2'd1;
  localparam logic [1:0] DIR_B    = 2'd2;
  localparam logic [1:0] DIR_BAD  = 2'd3;

  // register indexes
  localparam logic [CFG_IDXW-1:0] REG_PWM_PERIOD = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_WD_LIMIT   = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_LED_TMO    = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_LED_TOGGLE = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_HEARTBEAT  = 3'd4;

  // register reset values
  localparam logic [REG_W-1:0] RST_PWM_PERIOD = 16'd3600;
  localparam logic [REG_W-1:0] RST_WD_LIMIT   = 16'd1500;
  localparam logic [REG_W-1:0] RST_LED_TMO    = 16'd2500;
  localparam logic [REG_W-1:0] RST_LED_TOGGLE = 16'd250;
  localparam logic [REG_W-1:0] RST_HEARTBEAT  = 16'd1000;
  localparam logic [PERIOD_W-1:0] RST_REPORT_PERIOD = 7'd20;

  // input request
  typedef struct packed {
    logic [2:0]        opcode;
    logic              motor_sel;
    logic [1:0]        drive_dir;
    logic [DUTY_W-1:0] drive_duty;
    logic [7:0]        report_rate_hz;
  } cmd_t;

  // result request
  typedef struct packed {
    logic             status;
    logic [CMP_W-1:0] m1_cmp_a;
    logic [CMP_W-1:0] m1_cmp_b;
    logic [CMP_W-1:0] m2_cmp_a;
    logic [CMP_W-1:0] m2_cmp_b;
    logic             fault_event;
    logic             stopped_flag;
    logic             heartbeat_event;
    logic             encoder_event;
    logic             led_lit;
  } result_t;

  // classified command kinds
  typedef enum logic [3:0] {
    K_NOP,
    K_TICK,
    K_CONTACT,
    K_DRIVE,
    K_HALT_ONE,
    K_HALT_ALL,
    K_ENC_ON,
    K_ENC_OFF,
    K_BAD_RATE
  } kind_t;

  // classified command as queued between front and back
  typedef struct packed {
    kind_t               kind;
    logic                sel;
    logic [1:0]          dir;
    logic [DUTY_W-1:0]   duty;
    logic [PERIOD_W-1:0] period;
  } op_t;

  // encoder rate in hz to report period in ms, zero for an unsupported rate
  function automatic logic [PERIOD_W-1:0] rate_period(input logic [7:0] rate);
    logic [PERIOD_W-1:0] p;
    case (rate)
      8'd0:    p = 7'd20;
      8'd10:   p = 7'd100;
      8'd20:   p = 7'd50;
      8'd25:   p = 7'd40;
      8'd50:   p = 7'd20;
      8'd100:  p = 7'd10;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/dhb_front.sv @@
// dhb_front: accepts host requests and classifies them into queue entries
// depends on dhb_pkg
module dhb_front #(
  parameter int DUTY_FULL = 4095
) (
  input  logic           in_valid,
  output logic           in_ready,
  input  dhb_pkg::cmd_t  cmd,
  input  logic           q_full,
  output logic           push,
  output dhb_pkg::op_t   op
);

  localparam logic [dhb_pkg::REG_W-1:0] DUTY_MAX = dhb_pkg::REG_W'(DUTY_FULL);

  logic [dhb_pkg::PERIOD_W-1:0] period;
  logic                         duty_over;

  // handshake toward the queue
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign period    = dhb_pkg::rate_period(cmd.report_rate_hz);
  assign duty_over = {4'b0, cmd.drive_duty} > DUTY_MAX;

  // classify the request
  always_comb begin
    op.sel    = cmd.motor_sel;
    op.dir    = cmd.drive_dir;
    op.duty   = cmd.drive_duty;
    op.period = period;
    case (cmd.opcode)
      dhb_pkg::OP_TICK:       op.kind = dhb_pkg::K_TICK;
      dhb_pkg::OP_CONTACT:    op.kind = dhb_pkg::K_CONTACT;
      dhb_pkg::OP_DRIVE: begin
        // bad direction or duty above full scale is dropped without contact
        if (cmd.drive_dir == dhb_pkg::DIR_BAD || duty_over) begin
          op.kind = dhb_pkg::K_NOP;
        end else if (cmd.drive_dir == dhb_pkg::DIR_STOP || cmd.drive_duty == '0) begin
          op.kind = dhb_pkg::K_HALT_ONE;
        end else begin
          op.kind = dhb_pkg::K_DRIVE;
        end
      end
      dhb_pkg::OP_STOP_MOTOR: op.kind = dhb_pkg::K_HALT_ONE;
      dhb_pkg::OP_STOP_ALL:   op.kind = dhb_pkg::K_HALT_ALL;
      dhb_pkg::OP_ENC_ON: begin
        if (period == '0) begin
          op.kind = dhb_pkg::K_BAD_RATE;
        end else begin
          op.kind = dhb_pkg::K_ENC_ON;
        end
      end
      dhb_pkg::OP_ENC_OFF:    op.kind = dhb_pkg::K_ENC_OFF;
      default:                op.kind = dhb_pkg::K_NOP;
    endcase
  end

endmodule

@@ hw/rtl/dhb_fifo.sv @@
// dhb_fifo: short queue of classified commands between front and back
// depends on dhb_pkg
module dhb_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dhb_pkg::op_t  din,
  input  logic          pop,
  output dhb_pkg::op_t  dout,
  output logic          not_empty,
  output logic          full
);

  localparam int PTR_W = (dhb_pkg::QDEPTH > 1) ? $clog2(dhb_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(dhb_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(dhb_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(dhb_pkg::QDEPTH);

  dhb_pkg::op_t     mem [dhb_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign not_empty = count != '0;
  assign full      = count == DEPTH_C;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/dhb_back.sv @@
// dhb_back: carries out queued commands, keeps timers and motor state,
// and scales duty to pwm compare values in a five stage pipeline; depends on dhb_pkg
module dhb_back #(
  parameter int DUTY_FULL = 4095
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  dhb_pkg::op_t                  q_op,
  output logic                          q_pop,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dhb_pkg::CFG_IDXW-1:0]  cfg_index,
  input  logic [dhb_pkg::REG_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dhb_pkg::result_t              out_data
);

  localparam int CW    = dhb_pkg::CMP_W;
  localparam int PRW   = dhb_pkg::DUTY_W + dhb_pkg::REG_W;
  localparam int SH    = PRW + 1;
  localparam int MQW   = SH + CW;
  localparam int RECIP = (2 ** SH) / DUTY_FULL;
  localparam int MW    = $clog2(RECIP + 1);
  localparam logic [MW-1:0]  RECIP_V = MW'(RECIP);
  localparam logic [CW-1:0]  DIV_V   = CW'(DUTY_FULL);
  localparam logic [PRW-1:0] DIV_P   = PRW'(DUTY_FULL);

  typedef struct packed {
    logic status;
    logic fault;
    logic stopped;
    logic hb;
    logic enc;
    logic led;
  } flag_t;

  // configuration registers
  logic [dhb_pkg::REG_W-1:0] pwm_period;
  logic [dhb_pkg::REG_W-1:0] watchdog_limit_ms;
  logic [dhb_pkg::REG_W-1:0] led_timeout_ms;
  logic [dhb_pkg::REG_W-1:0] led_toggle_ms;
  logic [dhb_pkg::REG_W-1:0] heartbeat_ms;

  // block state
  logic [31:0]                   now_ms, now_ms_next;
  logic [31:0]                   last_contact, last_contact_next;
  logic                          wd_stopped, wd_stopped_next;
  logic                          contact_seen, contact_seen_next;
  logic [1:0]                    motor_dir [2];
  logic [1:0]                    motor_dir_next [2];
  logic [dhb_pkg::DUTY_W-1:0]    motor_duty [2];
  logic [dhb_pkg::DUTY_W-1:0]    motor_duty_next [2];
  logic [31:0]                   next_heartbeat, next_heartbeat_next;
  logic                          streaming, streaming_next;
  logic [dhb_pkg::PERIOD_W-1:0]  report_period_ms, report_period_ms_next;
  logic [31:0]                   next_report, next_report_next;
  logic [31:0]                   next_led_toggle, next_led_toggle_next;
  logic                          led_state, led_state_next;

  // tick arithmetic
  logic [31:0] now_plus;
  logic [31:0] tick_age;
  logic [31:0] hb_diff;
  logic [31:0] rep_diff;
  logic [31:0] led_diff;
  logic        connected;
  flag_t       flags;

  // pipeline
  logic                       adv;
  logic                       s1_vld, s2_vld, s3_vld, s4_vld;
  flag_t                      s1_flags, s2_flags, s3_flags, s4_flags;
  logic [1:0]                 s1_dir [2];
  logic [1:0]                 s2_dir [2];
  logic [1:0]                 s3_dir [2];
  logic [1:0]                 s4_dir [2];
  logic [dhb_pkg::DUTY_W-1:0] s1_duty [2];
  logic [PRW-1:0]             s2_p [2];
  logic [PRW-1:0]             s3_p [2];
  logic [PRW-1:0]             s4_p [2];
  logic [CW-1:0]              s3_q0 [2];
  logic [CW-1:0]              s4_q0 [2];
  logic [2*CW-1:0]            s4_qd [2];
  logic [MQW-1:0]             mq [2];
  logic [PRW-1:0]             rem [2];
  logic [CW-1:0]              q [2];

  assign cfg_ready = 1'b1;

  // whole pipeline moves unless a finished result is held
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period        <= dhb_pkg::RST_PWM_PERIOD;
      watchdog_limit_ms <= dhb_pkg::RST_WD_LIMIT;
      led_timeout_ms    <= dhb_pkg::RST_LED_TMO;
      led_toggle_ms     <= dhb_pkg::RST_LED_TOGGLE;
      heartbeat_ms      <= dhb_pkg::RST_HEARTBEAT;
    end else if (cfg_valid) begin
      case (cfg_index)
        dhb_pkg::REG_PWM_PERIOD: pwm_period        <= cfg_data;
        dhb_pkg::REG_WD_LIMIT:   watchdog_limit_ms <= cfg_data;
        dhb_pkg::REG_LED_TMO:    led_timeout_ms    <= cfg_data;
        dhb_pkg::REG_LED_TOGGLE: led_toggle_ms     <= cfg_data;
        dhb_pkg::REG_HEARTBEAT:  heartbeat_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  // time differences seen by a tick
  assign now_plus  = now_ms + 32'd1;
  assign tick_age  = now_plus - last_contact;
  assign hb_diff   = now_plus - next_heartbeat;
  assign rep_diff  = now_plus - next_report;
  assign led_diff  = now_plus - next_led_toggle;
  assign connected = contact_seen && (tick_age <= {16'b0, led_timeout_ms});

  // command execution
  always_comb begin
    now_ms_next           = now_ms;
    last_contact_next     = last_contact;
    wd_stopped_next       = wd_stopped;
    contact_seen_next     = contact_seen;
    motor_dir_next        = motor_dir;
    motor_duty_next       = motor_duty;
    next_heartbeat_next   = next_heartbeat;
    streaming_next        = streaming;
    report_period_ms_next = report_period_ms;
    next_report_next      = next_report;
    next_led_toggle_next  = next_led_toggle;
    led_state_next        = led_state;
    flags.status          = 1'b0;
    flags.fault           = 1'b0;
    flags.hb              = 1'b0;
    flags.enc             = 1'b0;

    // host contact for every accepted command but a tick, a dropped one or a rejected rate
    if (q_pop && q_op.kind != dhb_pkg::K_TICK && q_op.kind != dhb_pkg::K_NOP &&
        q_op.kind != dhb_pkg::K_BAD_RATE) begin
      last_contact_next = now_ms;
      wd_stopped_next   = 1'b0;
      contact_seen_next = 1'b1;
    end

    if (q_pop) begin
      case (q_op.kind)
        dhb_pkg::K_TICK: begin
          now_ms_next = now_plus;
          // watchdog
          if (!wd_stopped && tick_age > {16'b0, watchdog_limit_ms}) begin
            motor_dir_next[0]  = dhb_pkg::DIR_STOP;
            motor_dir_next[1]  = dhb_pkg::DIR_STOP;
            motor_duty_next[0] = '0;
            motor_duty_next[1] = '0;
            wd_stopped_next    = 1'b1;
            flags.fault        = 1'b1;
          end
          // heartbeat
          if (!hb_diff[31]) begin
            next_heartbeat_next = now_plus + {16'b0, heartbeat_ms};
            flags.hb            = 1'b1;
          end
          // encoder report schedule
          if (streaming && !rep_diff[31]) begin
            next_report_next = now_plus + {25'b0, report_period_ms};
            flags.enc        = 1'b1;
          end
          // connected blinker
          if (!connected) begin
            led_state_next       = 1'b0;
            next_led_toggle_next = now_plus;
          end else if (!led_diff[31]) begin
            next_led_toggle_next = now_plus + {16'b0, led_toggle_ms};
            led_state_next       = !led_state;
          end
        end
        dhb_pkg::K_DRIVE: begin
          motor_dir_next[q_op.sel]  = q_op.dir;
          motor_duty_next[q_op.sel] = q_op.duty;
        end
        dhb_pkg::K_HALT_ONE: begin
          motor_dir_next[q_op.sel]  = dhb_pkg::DIR_STOP;
          motor_duty_next[q_op.sel] = '0;
        end
        dhb_pkg::K_HALT_ALL: begin
          motor_dir_next[0]  = dhb_pkg::DIR_STOP;
          motor_dir_next[1]  = dhb_pkg::DIR_STOP;
          motor_duty_next[0] = '0;
          motor_duty_next[1] = '0;
        end
        dhb_pkg::K_ENC_ON: begin
          report_period_ms_next = q_op.period;
          streaming_next        = 1'b1;
          next_report_next      = now_ms;
        end
        dhb_pkg::K_ENC_OFF:  streaming_next = 1'b0;
        dhb_pkg::K_BAD_RATE: flags.status   = 1'b1;
        default: ;
      endcase
    end

    flags.stopped = wd_stopped_next;
    flags.led     = led_state_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms           <= '0;
      last_contact     <= '0;
      wd_stopped       <= 1'b0;
      contact_seen     <= 1'b0;
      motor_dir[0]     <= dhb_pkg::DIR_STOP;
      motor_dir[1]     <= dhb_pkg::DIR_STOP;
      motor_duty[0]    <= '0;
      motor_duty[1]    <= '0;
      next_heartbeat   <= {16'b0, dhb_pkg::RST_HEARTBEAT};
      streaming        <= 1'b0;
      report_period_ms <= dhb_pkg::RST_REPORT_PERIOD;
      next_report      <= '0;
      next_led_toggle  <= '0;
      led_state        <= 1'b0;
    end else begin
      now_ms           <= now_ms_next;
      last_contact     <= last_contact_next;
      wd_stopped       <= wd_stopped_next;
      contact_seen     <= contact_seen_next;
      motor_dir        <= motor_dir_next;
      motor_duty       <= motor_duty_next;
      next_heartbeat   <= next_heartbeat_next;
      streaming        <= streaming_next;
      report_period_ms <= report_period_ms_next;
      next_report      <= next_report_next;
      next_led_toggle  <= next_led_toggle_next;
      led_state        <= led_state_next;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      s4_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_vld    <= q_pop;
      s2_vld    <= s1_vld;
      s3_vld    <= s2_vld;
      s4_vld    <= s3_vld;
      out_valid <= s4_vld;
    end
  end

  // duty / full scale by reciprocal multiply, quotient low by at most one
  always_comb begin
    for (int m = 0; m < 2; m++) begin
      mq[m]  = MQW'(s2_p[m]) * MQW'(RECIP_V);
      rem[m] = s4_p[m] - s4_qd[m][PRW-1:0];
      q[m]   = (rem[m] >= DIV_P) ? s4_q0[m] + 1'b1 : s4_q0[m];
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags <= flags;
      s2_flags <= s1_flags;
      s3_flags <= s2_flags;
      s4_flags <= s3_flags;
      for (int m = 0; m < 2; m++) begin
        s1_dir[m]  <= motor_dir_next[m];
        s1_duty[m] <= motor_duty_next[m];
        s2_dir[m]  <= s1_dir[m];
        s2_p[m]    <= PRW'(s1_duty[m] * pwm_period);
        s3_dir[m]  <= s2_dir[m];
        s3_p[m]    <= s2_p[m];
        s3_q0[m]   <= mq[m][SH +: CW];
        s4_dir[m]  <= s3_dir[m];
        s4_p[m]    <= s3_p[m];
        s4_q0[m]   <= s3_q0[m];
        s4_qd[m]   <= s3_q0[m] * DIV_V;
      end
      out_data.status          <= s4_flags.status;
      out_data.m1_cmp_a        <= (s4_dir[0] == dhb_pkg::DIR_A) ? q[0] : '0;
      out_data.m1_cmp_b        <= (s4_dir[0] == dhb_pkg::DIR_B) ? q[0] : '0;
      out_data.m2_cmp_a        <= (s4_dir[1] == dhb_pkg::DIR_A) ? q[1] : '0;
      out_data.m2_cmp_b        <= (s4_dir[1] == dhb_pkg::DIR_B) ? q[1] : '0;
      out_data.fault_event     <= s4_flags.fault;
      out_data.stopped_flag    <= s4_flags.stopped;
      out_data.heartbeat_event <= s4_flags.hb;
      out_data.encoder_event   <= s4_flags.enc;
      out_data.led_lit         <= s4_flags.led;
    end
  end

`ifndef ASSERT_OFF
  // a watchdog stop keeps both bridges off until the next host contact
  a_stopped_motors_off: assert property (@(posedge clk) disable iff (rst)
    wd_stopped |-> motor_dir[0] == dhb_pkg::DIR_STOP && motor_dir[1] == dhb_pkg::DIR_STOP)
    else $error("motor running while watchdog stop is held");

  // a motor is stopped exactly when its duty is zero
  a_dir_duty_match: assert property (@(posedge clk) disable iff (rst)
    ((motor_dir[0] == dhb_pkg::DIR_STOP) == (motor_duty[0] == '0)) &&
    ((motor_dir[1] == dhb_pkg::DIR_STOP) == (motor_duty[1] == '0)))
    else $error("motor direction and duty disagree");

  // a fault result carries stopped motors
  a_fault_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fault_event |-> out_data.stopped_flag &&
    out_data.m1_cmp_a == '0 && out_data.m1_cmp_b == '0 &&
    out_data.m2_cmp_a == '0 && out_data.m2_cmp_b == '0)
    else $error("fault result with nonzero compare");

  // a rejected rate is never a tick
  a_status_no_events: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> !out_data.fault_event &&
    !out_data.heartbeat_event && !out_data.encoder_event)
    else $error("bad rate result carries tick events");
`endif

endmodule

@@ hw/rtl/dual_hbridge_drive_with_host_watchdog.sv @@
// dual_hbridge_drive_with_host_watchdog: top level of the dual h-bridge drive
// depends on dhb_pkg, dhb_front, dhb_fifo and dhb_back
//
// Usage:
//   in_valid/in_ready/in_data carry decoded host commands and 1 ms ticks
//   (dhb_pkg::cmd_t). out_valid/out_ready/out_data return one result per
//   command (dhb_pkg::result_t): the four pwm compare values, the watchdog
//   fault and stopped flags, heartbeat and encoder events, and the led.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five timing registers;
//   cfg_ready is always high. The user lets writes go in only while no
//   command is in flight; the block does not enforce this.
// Data path and throughput:
//   a result passes the queue, the state update register and the duty to
//   compare scaling (multiply, reciprocal multiply, back multiply,
//   remainder correction). One command is accepted per cycle unless stalled.
// Reset and stall:
//   rst clears the queue, the pipeline and all timers; registers return to
//   their defaults. When out_ready is low the pipeline holds, the 2-entry
//   queue fills, and in_ready falls once it is full.
module dual_hbridge_drive_with_host_watchdog #(
  parameter int DUTY_FULL = 4095
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dhb_pkg::cmd_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dhb_pkg::result_t              out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dhb_pkg::CFG_IDXW-1:0]  cfg_index,
  input  logic [dhb_pkg::REG_W-1:0]     cfg_data
);

  dhb_pkg::op_t push_op;
  dhb_pkg::op_t q_op;
  logic         push;
  logic         q_full;
  logic         q_valid;
  logic         q_pop;

  // request classification
  dhb_front #(
    .DUTY_FULL (DUTY_FULL)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (in_data),
    .q_full   (q_full),
    .push     (push),
    .op       (push_op)
  );

  // command queue
  dhb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_op),
    .pop       (q_pop),
    .dout      (q_op),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // execution and compare scaling
  dhb_back #(
    .DUTY_FULL (DUTY_FULL)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
